### rtl/core/byte_queue_with_pattern_search_core_assert.svh
// Assertion macros used by the checker file of the byte queue core.
// Needs nothing else; include by bare file name.
`ifndef BYTE_QUEUE_WITH_PATTERN_SEARCH_CORE_ASSERT_SVH
`define BYTE_QUEUE_WITH_PATTERN_SEARCH_CORE_ASSERT_SVH

// Property checked at every rising edge outside reset.
`define BQPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define BQPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/bqps_pkg.sv
// Shared types and constants of the byte queue with pattern search.
// No dependencies; the top level and the sequencer refer to it by scoped names.
`timescale 1ns / 1ps

package bqps_pkg;

  localparam int unsigned AddrWidth  = 10;
  localparam int unsigned Depth      = 1 << AddrWidth;
  localparam int unsigned CountWidth = AddrWidth + 1;
  localparam int unsigned MaxPattern = 8;
  localparam int unsigned PlenWidth  = 4;
  localparam int unsigned JWidth     = 3;
  localparam int unsigned PatWidth   = 8 * MaxPattern;

  // Configuration register indexes
  localparam logic CFG_PATTERN        = 1'b0;
  localparam logic CFG_PATTERN_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_DROP   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [AddrWidth-1:0]  position;
    logic [CountWidth-1:0] amount;
    logic [7:0]            data_byte;
  } item_t;

  typedef struct packed {
    logic [PatWidth-1:0]  pattern;
    logic [PlenWidth-1:0] pattern_length;
  } cfg_t;

  // First field in the highest bits
  typedef struct packed {
    logic                  overflow;
    logic [CountWidth-1:0] fill_level;
    logic [AddrWidth-1:0]  match_position;
    logic                  found;
    logic [7:0]            read_byte;
  } res_t;

  typedef struct packed {
    logic                 we;
    logic [AddrWidth-1:0] waddr;
    logic [7:0]           wdata;
    logic                 re;
    logic [AddrWidth-1:0] raddr;
  } mem_req_t;

endpackage

### rtl/core/byte_queue_with_pattern_search_core.sv
// Top level of the byte queue with pattern search: config registers, output
// register, sequencer and byte store. Depends on bqps_pkg, bqps_ctrl, bqps_ram.
`timescale 1ns / 1ps
// Usage
//   Commands enter on s_axis, cmd in tuser: append a byte, drop bytes from
//   the front, read the byte at an offset, or search for the configured
//   pattern at or after a start offset. Each command gives one result
//   transaction on m_axis, in order: read byte, found flag, match offset,
//   fill level after the command and append overflow flag.
//   The cfg channel writes the pattern (index 0) and its length (index 1);
//   write it only while no command is in flight. It is always ready.
// Throughput
//   Append and drop: one transaction per cycle while the output register is
//   free. Read: via the registered store read. Search: one byte compared at
//   a time, restarting at the next offset after a mismatch; no scan when the
//   pattern cannot fit. At most one command is in work at a time.
// Reset
//   The queue empties, pattern is zero and length one. The byte store is not
//   cleared: only bytes written by an append are ever read back.
// Stall
//   While the receiver stalls, the output register holds its result; one more
//   result parks in the sequencer, then s_axis_tready drops until room opens.

module byte_queue_with_pattern_search_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: tdata = data_byte[7:0], amount[18:8], position[28:19]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // tuser = cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  // master side: tdata = read_byte[7:0], found[8], match_position[18:9],
  // fill_level[29:19], overflow[30]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned AW = bqps_pkg::AddrWidth;
  localparam int unsigned CW = bqps_pkg::CountWidth;
  localparam int unsigned PW = bqps_pkg::PlenWidth;

  bqps_pkg::item_t    item;
  bqps_pkg::cfg_t     cfg_q;
  bqps_pkg::res_t     res, out_q;
  bqps_pkg::mem_req_t mem_req;
  logic               res_valid;
  logic               out_free;
  logic               m_valid_q, m_valid_d;
  logic [7:0]         mem_rdata;

  // Unpack the command transaction
  always_comb begin
    item.cmd       = bqps_pkg::cmd_e'(s_axis_tuser);
    item.data_byte = s_axis_tdata[7:0];
    item.amount    = s_axis_tdata[8 +: CW];
    item.position  = s_axis_tdata[8 + CW +: AW];
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern        <= '0;
      cfg_q.pattern_length <= PW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bqps_pkg::CFG_PATTERN:        cfg_q.pattern        <= cfg_data_i;
        bqps_pkg::CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data_i[PW-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  bqps_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .mem_o        (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  bqps_ram #(
    .AddrWidth (AW),
    .DataWidth (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: load a new result when empty or being drained
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

endmodule

### rtl/core/bqps_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bqps_ram #(
  parameter int unsigned AddrWidth = 10,
  parameter int unsigned DataWidth = 8
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem_q [1 << AddrWidth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/core/bqps_ctrl.sv
// Command sequencer: queue pointers, byte store access and the pattern scan.
// Depends on bqps_pkg.
`timescale 1ns / 1ps

module bqps_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  bqps_pkg::item_t    item_i,
  input  bqps_pkg::cfg_t     cfg_i,
  input  logic               out_free_i,
  output logic               res_valid_o,
  output bqps_pkg::res_t     res_o,
  output bqps_pkg::mem_req_t mem_o,
  input  logic [7:0]         mem_rdata_i
);

  localparam int unsigned AW = bqps_pkg::AddrWidth;
  localparam int unsigned CW = bqps_pkg::CountWidth;
  localparam int unsigned PW = bqps_pkg::PlenWidth;
  localparam int unsigned JW = bqps_pkg::JWidth;

  bqps_pkg::state_e state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    i_q, i_d;
  logic [JW-1:0]    j_q, j_d;
  logic [PW-1:0]    len_q, len_d;
  logic [AW-1:0]    last_q, last_d;
  logic             rd_ok_q, rd_ok_d;
  bqps_pkg::res_t   res_q, res_d;

  logic             rv;
  bqps_pkg::res_t   rn;
  logic             start_read, start_scan;
  logic [PW-1:0]    plen, len_m1;
  logic [CW-1:0]    count_left;
  logic             search_ok, match;
  logic [7:0]       pat_byte;
  logic [AW-1:0]    i_next;
  logic [JW-1:0]    j_next;

  assign item_ready_o = (state_q == bqps_pkg::ST_IDLE);

  // Saturate the pattern length and check that a match can fit at all
  always_comb begin
    plen = (cfg_i.pattern_length > PW'(bqps_pkg::MaxPattern)) ?
           PW'(bqps_pkg::MaxPattern) : cfg_i.pattern_length;
    count_left = count_q - CW'(plen);
    search_ok  = (plen != '0) && (CW'(plen) <= count_q) &&
                 ({1'b0, item_i.position} <= count_left);
    len_m1     = len_q - PW'(1);
    pat_byte   = cfg_i.pattern[{j_q, 3'b000} +: 8];
    match      = (mem_rdata_i == pat_byte);
  end

  // Datapath and result generation
  always_comb begin
    rv         = 1'b0;
    rn         = '0;
    rn.fill_level = count_q;
    head_d     = head_q;
    count_d    = count_q;
    i_d        = i_q;
    j_d        = j_q;
    len_d      = len_q;
    last_d     = last_q;
    rd_ok_d    = rd_ok_q;
    mem_o      = '0;
    start_read = 1'b0;
    start_scan = 1'b0;
    i_next     = i_q;
    j_next     = j_q;

    case (state_q)
      bqps_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          case (item_i.cmd)
            bqps_pkg::CMD_APPEND: begin
              rv = 1'b1;
              if (count_q == CW'(bqps_pkg::Depth)) begin
                rn.overflow = 1'b1;
              end else begin
                mem_o.we      = 1'b1;
                mem_o.waddr   = head_q + count_q[AW-1:0];
                mem_o.wdata   = item_i.data_byte;
                count_d       = count_q + CW'(1);
                rn.fill_level = count_d;
              end
            end
            bqps_pkg::CMD_DROP: begin
              rv = 1'b1;
              if (item_i.amount >= count_q) begin
                count_d = '0;
                head_d  = '0;
              end else begin
                head_d  = head_q + item_i.amount[AW-1:0];
                count_d = count_q - item_i.amount;
              end
              rn.fill_level = count_d;
            end
            bqps_pkg::CMD_READ: begin
              mem_o.re   = 1'b1;
              mem_o.raddr = head_q + item_i.position;
              rd_ok_d    = ({1'b0, item_i.position} < count_q);
              start_read = 1'b1;
            end
            bqps_pkg::CMD_SEARCH: begin
              mem_o.re    = 1'b1;
              mem_o.raddr = head_q + item_i.position;
              i_d         = item_i.position;
              j_d         = '0;
              len_d       = plen;
              last_d      = count_left[AW-1:0];
              if (search_ok) begin
                start_scan = 1'b1;
              end else begin
                rv = 1'b1;
              end
            end
            default: begin
              rv = 1'b1;
            end
          endcase
        end
      end
      bqps_pkg::ST_READ: begin
        rv           = 1'b1;
        rn.read_byte = rd_ok_q ? mem_rdata_i : 8'h00;
      end
      bqps_pkg::ST_SCAN: begin
        if (match && (j_q == len_m1[JW-1:0])) begin
          rv                = 1'b1;
          rn.found          = 1'b1;
          rn.match_position = i_q;
        end else if (!match && (i_q == last_q)) begin
          rv = 1'b1;
        end else begin
          // Advance within the candidate, or move to the next start offset
          if (match) begin
            j_next = j_q + JW'(1);
          end else begin
            i_next = i_q + AW'(1);
            j_next = '0;
          end
          i_d         = i_next;
          j_d         = j_next;
          mem_o.re    = 1'b1;
          mem_o.raddr = head_q + i_next + AW'(j_next);
        end
      end
      bqps_pkg::ST_EMIT: begin
        rv = 1'b1;
        rn = res_q;
      end
      default: begin
        rv = 1'b0;
      end
    endcase

    res_d = (rv && !out_free_i) ? rn : res_q;
  end

  assign res_valid_o = rv && out_free_i;
  assign res_o       = rn;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bqps_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          if (start_read) begin
            state_d = bqps_pkg::ST_READ;
          end else if (start_scan) begin
            state_d = bqps_pkg::ST_SCAN;
          end else if (!out_free_i) begin
            state_d = bqps_pkg::ST_EMIT;
          end
        end
      end
      bqps_pkg::ST_READ, bqps_pkg::ST_SCAN, bqps_pkg::ST_EMIT: begin
        if (rv) begin
          state_d = out_free_i ? bqps_pkg::ST_IDLE : bqps_pkg::ST_EMIT;
        end
      end
      default: begin
        state_d = bqps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqps_pkg::ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    len_q   <= len_d;
    last_q  <= last_d;
    rd_ok_q <= rd_ok_d;
    res_q   <= res_d;
  end

endmodule

### rtl/core/bqps_checker.sv
// Port-level checks of the byte queue core, bound to the top level.
// Depends on byte_queue_with_pattern_search_core_assert.svh.
`timescale 1ns / 1ps
`include "byte_queue_with_pattern_search_core_assert.svh"

module bqps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Hold a stalled result unchanged
  `BQPS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Fill level never exceeds the queue depth
  `BQPS_ASSERT(a_fill_range, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[29:19] <= 11'd1024, "fill level above depth")

  // A dropped append only happens on a full queue
  `BQPS_ASSERT(a_ovf_full, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[30] |-> m_axis_tdata[29:19] == 11'd1024, "overflow without full queue")

  // No match offset without a match
  `BQPS_ASSERT(a_pos_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[18:9] == 10'd0, "match offset set without match")

  // No result during reset
  `BQPS_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid in reset")

endmodule

bind byte_queue_with_pattern_search_core bqps_checker u_bqps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
